FILE: src/bda_pkg.sv
`timescale 1ns / 1ps

package bda_pkg;

  localparam int ValueW        = 16;
  localparam int BcdDigits     = 5;
  localparam int BcdW          = 4 * BcdDigits;
  localparam int CharW         = 6;
  localparam int OutDataW      = 8;
  localparam int NumStages     = 4;
  localparam int StepsPerStage = ValueW / NumStages;
  localparam int IdxW          = $clog2(BcdDigits);

  localparam logic [CharW-1:0] AsciiZero = 6'd48;
  localparam logic [CharW-1:0] AsciiNine = 6'd57;

  // bcd digits above, binary bits still to be shifted in below
  typedef struct packed {
    logic [BcdW-1:0]   bcd;
    logic [ValueW-1:0] bin;
  } dab_t;

  // several shift-and-add-3 steps of the double dabble conversion
  function automatic dab_t dabble_steps(input dab_t din);
    dab_t        w;
    logic [3:0]  dig;
    w = din;
    for (int s = 0; s < StepsPerStage; s++) begin
      for (int d = 0; d < BcdDigits; d++) begin
        dig = w.bcd[4*d +: 4];
        if (dig >= 4'd5) begin
          w.bcd[4*d +: 4] = dig + 4'd3;
        end
      end
      w = {w[$bits(dab_t)-2:0], 1'b0};
    end
    return w;
  endfunction

endpackage

FILE: src/binary_to_decimal_ascii_core.sv
`timescale 1ns / 1ps

// binary to decimal ascii: each input transaction carries one unsigned 16-bit value,
// and the block sends its decimal digits as ascii characters, most significant first,
// with leading zeros dropped (zero gives a single '0'); tlast marks the final digit.
// the conversion runs as a four-stage double dabble pipeline (four shift steps per
// stage) that can take a new value every cycle while no later stage is held, followed
// by a digit emitter that sends one character per cycle while the output is ready.
// a value passes the stage registers and then the emitter register before its first
// digit appears; an item holds the emitter until its last digit leaves, and that
// emitter sets the sustained rate. back-pressure on the output stalls the pipeline
// without losing or repeating anything. no state survives from one value to the next.
module binary_to_decimal_ascii_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [bda_pkg::ValueW-1:0]  s_axis_tdata,   // [15:0] value
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [bda_pkg::OutDataW-1:0] m_axis_tdata,  // [5:0] digit_char, [7:6] zero
  output logic                        m_axis_tlast    // is_last
);
  import bda_pkg::*;

  // conversion pipeline registers
  logic [NumStages-1:0] vld_q, vld_d;
  dab_t                 dab_q [NumStages];
  logic [NumStages:0]   stg_rdy;   // stg_rdy[k]: stage k may load, top bit is the emitter

  // digit emitter
  logic             emit_vld_q, emit_vld_d;
  logic [BcdW-1:0]  emit_bcd_q, emit_bcd_d;
  logic [IdxW-1:0]  emit_idx_q, emit_idx_d;
  logic [IdxW-1:0]  lead_idx;
  logic             emit_load;
  logic             m_hs;
  logic [3:0]       cur_dig;

  assign m_hs      = m_axis_tvalid && m_axis_tready;
  // emitter frees up when empty or when its last digit leaves
  assign emit_load = !emit_vld_q || (m_hs && (emit_idx_q == '0));

  // ready ripples back: a stage can load when empty or when the next one takes its item
  always_comb begin
    stg_rdy[NumStages] = emit_load;
    for (int k = NumStages - 1; k >= 0; k--) begin
      stg_rdy[k] = !vld_q[k] || stg_rdy[k+1];
    end
  end

  assign s_axis_tready = stg_rdy[0];

  always_comb begin
    vld_d[0] = stg_rdy[0] ? s_axis_tvalid : vld_q[0];
    for (int k = 1; k < NumStages; k++) begin
      vld_d[k] = stg_rdy[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // payload moves only with a load, so a stall holds it
  always_ff @(posedge clk_i) begin
    if (stg_rdy[0] && s_axis_tvalid) begin
      dab_q[0] <= dabble_steps(dab_t'{bcd: '0, bin: s_axis_tdata});
    end
    for (int k = 1; k < NumStages; k++) begin
      if (stg_rdy[k] && vld_q[k-1]) begin
        dab_q[k] <= dabble_steps(dab_q[k-1]);
      end
    end
  end

  // position of the most significant non-zero digit, units when all are zero
  always_comb begin
    lead_idx = '0;
    for (int d = 1; d < BcdDigits; d++) begin
      if (dab_q[NumStages-1].bcd[4*d +: 4] != 4'd0) begin
        lead_idx = IdxW'(d);
      end
    end
  end

  always_comb begin
    emit_vld_d = emit_vld_q;
    emit_bcd_d = emit_bcd_q;
    emit_idx_d = emit_idx_q;
    if (emit_load) begin
      emit_vld_d = vld_q[NumStages-1];
      emit_bcd_d = dab_q[NumStages-1].bcd;
      emit_idx_d = lead_idx;
    end else if (m_hs) begin
      emit_idx_d = emit_idx_q - IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_vld_q <= 1'b0;
    end else begin
      emit_vld_q <= emit_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    emit_bcd_q <= emit_bcd_d;
    emit_idx_q <= emit_idx_d;
  end

  // current digit straight from the emitter register
  assign cur_dig       = emit_bcd_q[4*emit_idx_q +: 4];
  assign m_axis_tvalid = emit_vld_q;
  assign m_axis_tdata  = {{(OutDataW-CharW){1'b0}}, AsciiZero + {2'b00, cur_dig}};
  assign m_axis_tlast  = (emit_idx_q == '0);

endmodule

FILE: src/bda_checker.sv
`timescale 1ns / 1ps

module bda_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [bda_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                         m_axis_tlast
);
  import bda_pkg::*;

  logic       mid_run_q;
  logic [2:0] run_cnt_q;
  logic       m_hs;

  assign m_hs  = m_axis_tvalid && m_axis_tready;

  // tracks whether a run of digits has started on the output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_run_q <= 1'b0;
      run_cnt_q <= '0;
    end else if (m_hs) begin
      mid_run_q <= !m_axis_tlast;
      run_cnt_q <= m_axis_tlast ? 3'd0 : run_cnt_q + 3'd1;
    end
  end

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped while stalled");

  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output transaction changed while stalled");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OutDataW-1:CharW] == '0
                   && m_axis_tdata[CharW-1:0] >= AsciiZero
                   && m_axis_tdata[CharW-1:0] <= AsciiNine)
    else $error("output character is not a decimal digit");

  a_no_leading_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !mid_run_q && !m_axis_tlast |-> m_axis_tdata[CharW-1:0] != AsciiZero)
    else $error("leading zero sent");

  a_run_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && run_cnt_q == 3'(BcdDigits - 1) |-> m_axis_tlast)
    else $error("run longer than five digits");

endmodule

bind binary_to_decimal_ascii_core bda_checker u_bda_checker (.*);

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  import bda_pkg::*;

  localparam int Radix       = 10;
  localparam int NumDirected = 22;
  localparam int NumRandom   = 480;
  localparam int DrainAt     = 240;
  localparam int TailCycles  = 30;

  // one expected output transaction
  typedef struct packed {
    logic [CharW-1:0] digit_char;
    logic             is_last;
  } digit_result_t;

  // directed row: digit count 0 means the predictor works out the digits,
  // otherwise text holds the expected characters right-justified
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [2:0]        n_typed;
    logic [39:0]       text;
  } stim_row_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [ValueW-1:0]   s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  digit_result_t expected_digits_q[$];
  int            error_count     = 0;
  int            values_sent     = 0;
  int            chars_checked   = 0;
  int            send_burst      = 0;
  int            ready_burst     = 0;
  int            ready_stall     = 0;
  int            length_seen [1:5];

  stim_row_t directed_rows [NumDirected] = '{
    '{16'd0,     3'd1, "0"},
    '{16'd1,     3'd1, "1"},
    '{16'd9,     3'd1, "9"},
    '{16'd10,    3'd2, "10"},
    '{16'd99,    3'd2, "99"},
    '{16'd100,   3'd3, "100"},
    '{16'd999,   3'd3, "999"},
    '{16'd1000,  3'd4, "1000"},
    '{16'd9999,  3'd4, "9999"},
    '{16'd10000, 3'd5, "10000"},
    '{16'd65535, 3'd5, "65535"},
    '{16'd0,     3'd1, "0"},
    '{16'd65534, 3'd0, 40'd0},
    '{16'd32768, 3'd0, 40'd0},
    '{16'd12345, 3'd0, 40'd0},
    '{16'h5555,  3'd0, 40'd0},
    '{16'hAAAA,  3'd0, 40'd0},
    '{16'd40004, 3'd0, 40'd0},
    '{16'd59999, 3'd0, 40'd0},
    '{16'd7,     3'd0, 40'd0},
    '{16'd1234,  3'd0, 40'd0},
    '{16'd101,   3'd0, 40'd0}
  };

  binary_to_decimal_ascii_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // decimal digits of a value, most significant first, leading zeros dropped
  function automatic void queue_decimal_digits(input logic [ValueW-1:0] value);
    int unsigned   rest;
    int            n;
    logic [3:0]    dig [5];
    digit_result_t r;
    rest = {16'd0, value};
    n    = 0;
    do begin
      dig[n] = 4'(rest % Radix);
      rest   = rest / Radix;
      n++;
    end while (rest != 0);
    length_seen[n]++;
    for (int k = n - 1; k >= 0; k--) begin
      r.digit_char = AsciiZero + CharW'(dig[k]);
      r.is_last    = (k == 0);
      expected_digits_q.push_back(r);
    end
  endfunction

  function automatic void queue_typed_digits(input stim_row_t row);
    digit_result_t r;
    length_seen[row.n_typed]++;
    for (int k = 0; k < row.n_typed; k++) begin
      r.digit_char = row.text[8*(row.n_typed-1-k) +: CharW];
      r.is_last    = (k == row.n_typed - 1);
      expected_digits_q.push_back(r);
    end
  endfunction

  // mostly back-to-back, some short gaps, a few long ones, now and then a run with none
  function automatic int next_send_gap();
    if (send_burst > 0) begin
      send_burst--;
      return 0;
    end
    case ($urandom_range(0, 19))
      0:             begin
        send_burst = $urandom_range(10, 40);
        return 0;
      end
      1:             return $urandom_range(15, 40);
      2, 3, 4, 5, 6: return $urandom_range(1, 3);
      default:       return 0;
    endcase
  endfunction

  // weighted towards each digit count and the decade boundaries
  function automatic logic [ValueW-1:0] random_value();
    int unsigned decade;
    case ($urandom_range(0, 7))
      0:       return ValueW'($urandom_range(0, 9));
      1:       return ValueW'($urandom_range(10, 99));
      2:       return ValueW'($urandom_range(100, 999));
      3:       return ValueW'($urandom_range(1000, 9999));
      4:       begin
        decade = 1;
        repeat ($urandom_range(0, 4)) decade = decade * Radix;
        return ValueW'(decade + $urandom_range(0, 2) - 1);
      end
      5:       return ValueW'(16'hFFFF - $urandom_range(0, 15));
      default: return ValueW'($urandom);
    endcase
  endfunction

  // called just after a rising edge; returns just after the accepting edge
  task automatic send_value(input stim_row_t row, input bit drain);
    int gap;
    gap = next_send_gap();
    if (drain) gap = gap + 1;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= ValueW'($urandom);
      repeat (gap) @(posedge clk_i);
      while (drain && expected_digits_q.size() != 0) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= row.value;
    do @(posedge clk_i); while (!s_axis_tready);
    if (row.n_typed != 0) queue_typed_digits(row);
    else queue_decimal_digits(row.value);
    values_sent++;
  endtask

  // output side back-pressure
  always @(posedge clk_i) begin
    if (ready_burst > 0) begin
      ready_burst--;
      m_axis_tready <= 1'b1;
    end else if (ready_stall > 0) begin
      ready_stall--;
      m_axis_tready <= 1'b0;
    end else begin
      case ($urandom_range(0, 9))
        0:       ready_burst = $urandom_range(20, 80);
        1:       ready_stall = $urandom_range(10, 40);
        2, 3, 4: ready_stall = $urandom_range(1, 3);
        default: ;
      endcase
      m_axis_tready <= (ready_stall == 0);
    end
  end

  // compare each output transaction with the oldest expectation
  always @(posedge clk_i) begin : result_check
    digit_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_digits_q.size() == 0) begin
        $display("%0t: unexpected transaction, char %0d last %0b", $time,
                 m_axis_tdata[CharW-1:0], m_axis_tlast);
        error_count++;
      end else begin
        want = expected_digits_q.pop_front();
        chars_checked++;
        if (m_axis_tdata[CharW-1:0] !== want.digit_char) begin
          $display("%0t: digit_char expected %0d actual %0d", $time,
                   want.digit_char, m_axis_tdata[CharW-1:0]);
          error_count++;
        end
        if (m_axis_tlast !== want.is_last) begin
          $display("%0t: is_last expected %0b actual %0b", $time,
                   want.is_last, m_axis_tlast);
          error_count++;
        end
        if (m_axis_tdata[OutDataW-1:CharW] !== '0) begin
          $display("%0t: tdata padding expected 0 actual %0b", $time,
                   m_axis_tdata[OutDataW-1:CharW]);
          error_count++;
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t row;
    for (int i = 1; i <= 5; i++) length_seen[i] = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) send_value(directed_rows[i], 1'b0);

    for (int i = 0; i < NumRandom; i++) begin
      row.value   = random_value();
      row.n_typed = 3'd0;
      row.text    = '0;
      send_value(row, i == DrainAt);
    end
    s_axis_tvalid <= 1'b0;

    while (expected_digits_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("%0d values sent (%0d directed), %0d digit characters checked", values_sent,
             NumDirected, chars_checked);
    $display("values by digit count 1..5: %0d %0d %0d %0d %0d", length_seen[1],
             length_seen[2], length_seen[3], length_seen[4], length_seen[5]);
    if (error_count == 0 && expected_digits_q.size() == 0) begin
      $display("[binary_to_decimal_ascii_core] OK");
    end else begin
      $display("[binary_to_decimal_ascii_core] ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d characters outstanding", expected_digits_q.size());
    $display("[binary_to_decimal_ascii_core] ERROR");
    $finish;
  end

endmodule
